// ----- rtl/core/bls_pkg.sv -----
// Shared types and codes for the line stepper.
// No dependencies; used by bls_step, bls_emit and bresenham_line_stepper_top.
package bls_pkg;

  // Request kinds on the input channel.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Octant classes after the endpoints are ordered by x.
  localparam logic [1:0] SLOPE_SHALLOW_UP   = 2'd0;
  localparam logic [1:0] SLOPE_STEEP_UP     = 2'd1;
  localparam logic [1:0] SLOPE_SHALLOW_DOWN = 2'd2;
  localparam logic [1:0] SLOPE_STEEP_DOWN   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIRROR_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y    = 2'd2;

  // Eightfold reflection slots.
  localparam int unsigned MIRROR_SLOTS = 8;
  localparam int unsigned SLOT_BITS    = $clog2(MIRROR_SLOTS);

  // Per-pixel control handed from the stepper to the emitter.
  typedef struct packed {
    logic mirror;
    logic done;
  } bls_run_t;

endpackage

// ----- rtl/core/bls_step.sv -----
// Line setup and Bresenham stepping state.
// Depends on bls_pkg; feeds the current pixel to bls_emit.
module bls_step #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  output logic                         pix_fire,
  output logic signed [COORD_BITS-1:0] pix_x,
  output logic signed [COORD_BITS-1:0] pix_y,
  output logic                         pix_done
);

  localparam int SW = COORD_BITS + 1;  // span width
  localparam int DW = COORD_BITS + 5;  // decision width

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] stop_x_r, stop_x_nxt, stop_y_r, stop_y_nxt;
  logic signed [SW-1:0]         span_w_r, span_w_nxt, span_h_r, span_h_nxt;
  logic signed [DW-1:0]         decision_r, decision_nxt;
  logic [1:0]                   slope_r, slope_nxt;

  logic                         swap;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic signed [SW:0]           w_e, h_e;
  logic signed [DW-1:0]         wl, hl, wr, hr, dec_load;
  logic [1:0]                   slope_load;
  logic                         done;

  // Order endpoints so x never decreases.
  assign swap = first_x > second_x;
  assign ax = swap ? second_x : first_x;
  assign ay = swap ? second_y : first_y;
  assign bx = swap ? first_x : second_x;
  assign by = swap ? first_y : second_y;

  assign span_w_nxt = SW'(bx) - SW'(ax);
  assign span_h_nxt = SW'(by) - SW'(ay);
  assign w_e = (SW + 1)'(span_w_nxt);
  assign h_e = (SW + 1)'(span_h_nxt);
  assign wl  = DW'(span_w_nxt);
  assign hl  = DW'(span_h_nxt);

  always_comb begin
    if (!h_e[SW] && (w_e >= h_e)) begin
      slope_load = bls_pkg::SLOPE_SHALLOW_UP;
      dec_load   = (hl <<< 1) - wl;
    end else if (!h_e[SW]) begin
      slope_load = bls_pkg::SLOPE_STEEP_UP;
      dec_load   = (wl <<< 1) - hl;
    end else if (w_e > -h_e) begin
      slope_load = bls_pkg::SLOPE_SHALLOW_DOWN;
      dec_load   = (hl <<< 1) + wl;
    end else begin
      slope_load = bls_pkg::SLOPE_STEEP_DOWN;
      dec_load   = (wl <<< 1) + hl;
    end
  end

  assign wr = DW'(span_w_r);
  assign hr = DW'(span_h_r);

  assign done = ((slope_r == bls_pkg::SLOPE_SHALLOW_UP) ||
                 (slope_r == bls_pkg::SLOPE_SHALLOW_DOWN)) ? (cur_x_r == stop_x_r)
                                                           : (cur_y_r == stop_y_r);

  assign pix_fire = in_fire && (in_action == bls_pkg::ACT_STEP) && active_r;
  assign pix_x    = cur_x_r;
  assign pix_y    = cur_y_r;
  assign pix_done = done;

  always_comb begin
    active_nxt   = active_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    stop_x_nxt   = stop_x_r;
    stop_y_nxt   = stop_y_r;
    decision_nxt = decision_r;
    slope_nxt    = slope_r;
    if (in_fire && (in_action == bls_pkg::ACT_LOAD)) begin
      active_nxt   = 1'b1;
      cur_x_nxt    = ax;
      cur_y_nxt    = ay;
      stop_x_nxt   = bx;
      stop_y_nxt   = by;
      decision_nxt = dec_load;
      slope_nxt    = slope_load;
    end else if (pix_fire) begin
      if (done) begin
        active_nxt = 1'b0;
      end else begin
        unique case (slope_r)
          bls_pkg::SLOPE_SHALLOW_UP: begin
            if (decision_r < 0) begin
              decision_nxt = decision_r + (hr <<< 1);
            end else begin
              cur_y_nxt    = cur_y_r + COORD_BITS'(1);
              decision_nxt = decision_r + ((hr - wr) <<< 1);
            end
            cur_x_nxt = cur_x_r + COORD_BITS'(1);
          end
          bls_pkg::SLOPE_STEEP_UP: begin
            if (decision_r < 0) begin
              decision_nxt = decision_r + (wr <<< 1);
            end else begin
              cur_x_nxt    = cur_x_r + COORD_BITS'(1);
              decision_nxt = decision_r + ((wr - hr) <<< 1);
            end
            cur_y_nxt = cur_y_r + COORD_BITS'(1);
          end
          bls_pkg::SLOPE_SHALLOW_DOWN: begin
            if (decision_r < 0) begin
              cur_y_nxt    = cur_y_r - COORD_BITS'(1);
              decision_nxt = decision_r + ((hr + wr) <<< 1);
            end else begin
              decision_nxt = decision_r + (hr <<< 1);
            end
            cur_x_nxt = cur_x_r + COORD_BITS'(1);
          end
          default: begin
            if (decision_r > 0) begin
              cur_x_nxt    = cur_x_r + COORD_BITS'(1);
              decision_nxt = decision_r + ((hr + wr) <<< 1);
            end else begin
              decision_nxt = decision_r + (wr <<< 1);
            end
            cur_y_nxt = cur_y_r - COORD_BITS'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    stop_x_r   <= stop_x_nxt;
    stop_y_r   <= stop_y_nxt;
    decision_r <= decision_nxt;
    slope_r    <= slope_nxt;
    if (in_fire && (in_action == bls_pkg::ACT_LOAD)) begin
      span_w_r <= span_w_nxt;
      span_h_r <= span_h_nxt;
    end
  end

  // A step that emits the final pixel leaves the stepper idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_fire && done) |=> !active_r)
    else $error("stepper still active after final pixel");

endmodule

// ----- rtl/core/bls_emit.sv -----
// Result stage: holds one pixel and emits it once or as eight reflections.
// Depends on bls_pkg; driven by bls_step through the top level.
module bls_emit #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] load_x,
  input  logic signed [COORD_BITS-1:0] load_y,
  input  bls_pkg::bls_run_t            load_ctl,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_pixel_x,
  output logic signed [COORD_BITS:0]   out_pixel_y,
  output logic                         out_last_of_run,
  output logic                         out_line_done
);

  localparam int OW = COORD_BITS + 1;

  logic                             valid_r;
  logic [bls_pkg::SLOT_BITS-1:0]    slot_r;
  logic signed [COORD_BITS-1:0]     x_r, y_r;
  bls_pkg::bls_run_t                ctl_r;
  logic                             last;
  logic                             out_fire;
  logic signed [COORD_BITS-1:0]     src_a, src_b;
  logic signed [OW-1:0]             mx, my;

  assign last = !ctl_r.mirror ||
                (slot_r == bls_pkg::SLOT_BITS'(bls_pkg::MIRROR_SLOTS - 1));
  assign out_fire = valid_r && out_ready;
  assign free     = !valid_r || (out_ready && last);

  // Upper four slots swap the roles of x and y; bit 0 negates the x term,
  // bit 1 the y term.
  assign src_a = slot_r[2] ? y_r : x_r;
  assign src_b = slot_r[2] ? x_r : y_r;
  assign mx = slot_r[0] ? (OW'(center_x) - OW'(src_a)) : (OW'(center_x) + OW'(src_a));
  assign my = slot_r[1] ? (OW'(center_y) - OW'(src_b)) : (OW'(center_y) + OW'(src_b));

  assign out_valid       = valid_r;
  assign out_pixel_x     = ctl_r.mirror ? mx : OW'(x_r);
  assign out_pixel_y     = ctl_r.mirror ? my : OW'(y_r);
  assign out_last_of_run = last;
  assign out_line_done   = ctl_r.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      slot_r  <= '0;
    end else if (out_fire) begin
      if (last) begin
        valid_r <= 1'b0;
      end
      slot_r <= slot_r + bls_pkg::SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r   <= load_x;
      y_r   <= load_y;
      ctl_r <= load_ctl;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("pixel loaded over a run still in flight");

  a_plain_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !ctl_r.mirror) |-> (slot_r == '0))
    else $error("plain mode advanced past first slot");

  a_run_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && last && !load) |=> !valid_r)
    else $error("result stage stayed valid after final slot");

endmodule

// ----- rtl/core/bresenham_line_stepper_top.sv -----
// Latency: a step request accepted at one edge shows its first result right after it.
// Throughput: one step request per cycle in plain mode while out_ready is high; a step in
// mirror mode holds the result stage for eight reflections (one per cycle with out_ready high), so the next request
// waits. Load requests and steps while idle take one cycle and give no result.
// Reset (rst_n low, synchronous) idles the stepper, empties the result stage and
// clears the configuration registers; no clearing pass is needed.
module bresenham_line_stepper_top #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [bls_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_pixel_x,
  output logic signed [COORD_BITS:0]   out_pixel_y,
  output logic                         out_last_of_run,
  output logic                         out_line_done
);

  logic                         mirror_mode_r;
  logic signed [COORD_BITS-1:0] center_x_r;
  logic signed [COORD_BITS-1:0] center_y_r;

  logic                         in_fire;
  logic                         emit_free;
  logic                         pix_fire;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic                         pix_done;
  bls_pkg::bls_run_t            pix_ctl;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_mode_r <= 1'b0;
      center_x_r    <= '0;
      center_y_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bls_pkg::REG_MIRROR_MODE: mirror_mode_r <= cfg_data[0];
        bls_pkg::REG_CENTER_X:    center_x_r    <= $signed(cfg_data);
        bls_pkg::REG_CENTER_Y:    center_y_r    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Take a new request whenever the result stage is empty or hands over its
  // last slot this cycle; the stepper state advances at acceptance, so the
  // next step can follow immediately.
  assign in_ready = emit_free;
  assign in_fire  = in_valid && in_ready;

  bls_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_action(in_action),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .pix_fire (pix_fire),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .pix_done (pix_done)
  );

  // Latch the mode with the pixel so its run keeps one shape.
  always_comb begin
    pix_ctl.mirror = mirror_mode_r;
    pix_ctl.done   = pix_done;
  end

  bls_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (pix_fire),
    .load_x         (pix_x),
    .load_y         (pix_y),
    .load_ctl       (pix_ctl),
    .center_x       (center_x_r),
    .center_y       (center_y_r),
    .free           (emit_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_of_run(out_last_of_run),
    .out_line_done  (out_line_done)
  );

endmodule
